// ===== rtl/core/sict_pkg.sv =====
// ----------------------------------------------------------------------------
// sict_pkg: shared types and constants of the id compaction table
// Table depth, index widths, request and result items, status codes and the
// search item that travels along the chain of search cells.
// ----------------------------------------------------------------------------
package sict_pkg;

	localparam int unsigned TABLE_DEPTH = 1024;
	localparam int unsigned ID_W        = 40;
	localparam int unsigned IDX_W       = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W       = IDX_W + 1;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_OOO  = 2'd2;

	localparam logic REQ_ASSIGN = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	typedef struct packed {
		logic            req_type;
		logic [ID_W-1:0] node_id;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0] new_id;
		logic [ID_W-1:0] run_start;
		logic [ID_W-1:0] run_new_start;
		logic [1:0]      status;
	} rsp_t;

	// One table entry: the old id at the start of a run and its dense id.
	typedef struct packed {
		logic [ID_W-1:0] key;
		logic [ID_W-1:0] val;
	} run_ent_t;

	// Search item handed from one cell to the next.
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] prefix;
		logic [ID_W-1:0]  id;
		run_ent_t         best;
	} srch_t;

endpackage

// ===== rtl/core/sict_ram.sv =====
// ----------------------------------------------------------------------------
// sict_ram: simple dual-port table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sict_ram
	import sict_pkg::*;
#(
	parameter int unsigned DEPTH = 2,
	parameter int unsigned AW    = 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  run_ent_t      wdata,
	input  logic [AW-1:0] raddr,
	output run_ent_t      rdata
);

	run_ent_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/sict_cell.sv =====
// ----------------------------------------------------------------------------
// sict_cell: one step of the chained predecessor search
// Decides one bit of the matching entry index. The cell owns the entries whose
// lowest set index bit is its level; their memory is read as the item enters.
// ----------------------------------------------------------------------------
module sict_cell
	import sict_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] level,
	input  logic [CNT_W-1:0] count,
	input  srch_t            up,
	input  run_ent_t         rdata,
	output srch_t            down
);

	logic             valid_q;
	logic [IDX_W-1:0] prefix_q;
	logic [ID_W-1:0]  id_q;
	run_ent_t         best_q;
	logic [IDX_W-1:0] cand;
	logic             hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		prefix_q <= up.prefix;
		id_q     <= up.id;
		best_q   <= up.best;
	end

	// The candidate entry is taken only if it exists and its key is not above the id.
	assign cand = prefix_q | level;
	assign hit  = ({1'b0, cand} < count) && (rdata.key <= id_q);

	always_comb begin
		down.valid  = valid_q;
		down.id     = id_q;
		down.prefix = hit ? cand : prefix_q;
		down.best   = hit ? rdata : best_q;
	end

endmodule

// ===== rtl/core/sparse_id_compaction_table_unit.sv =====
// ----------------------------------------------------------------------------
// sparse_id_compaction_table_unit: dense id assignment with run table search
// Hands out dense ids for ascending sparse ids, records run starts in a sorted
// table and finds the run entry that covers a given id.
// ----------------------------------------------------------------------------
//  channel   | ports                 | handshake
//  ----------+-----------------------+-------------------------------------
//  request   | start, busy, req      | taken when start is high, busy low
//  result    | done, result          | done marks each item's result
//
// An assign item's result appears in the next cycle and a new item may be
// started at once. A lookup item walks one search cell per index bit (IDX_W
// cells, each with a registered memory read) and then the result register;
// busy is high after it is taken until its result appears.
// Reset empties the table to its single entry (0,0); the memories need no
// clearing since only entries below the entry count are ever used.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module sparse_id_compaction_table_unit
	import sict_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t result
);

	logic             busy_q;
	logic             done_q;
	rsp_t             result_q;
	logic [CNT_W-1:0] count_q;
	logic [ID_W-1:0]  last_key_q;
	logic [ID_W-1:0]  expected_q;
	logic [ID_W-1:0]  dense_q;

	logic             accept;
	logic             assign_go;
	logic             need_app;
	logic             ooo;
	logic             full;
	logic             append_en;
	logic [1:0]       asg_status;
	run_ent_t         wr_ent;

	srch_t            link [IDX_W+1];

	assign accept    = start && !busy_q;
	assign assign_go = accept && (req.req_type == REQ_ASSIGN);
	assign need_app  = req.node_id != expected_q;
	assign ooo       = req.node_id <= last_key_q;
	assign full      = count_q == CNT_W'(TABLE_DEPTH);
	assign append_en = assign_go && need_app && !ooo && !full;

	always_comb begin
		asg_status = STATUS_OK;
		if (need_app) begin
			if (ooo) begin
				asg_status = STATUS_OOO;
			end else if (full) begin
				asg_status = STATUS_FULL;
			end
		end
	end

	assign wr_ent.key = req.node_id;
	assign wr_ent.val = dense_q;

	always_comb begin
		link[IDX_W].valid  = accept && (req.req_type == REQ_LOOKUP);
		link[IDX_W].prefix = '0;
		link[IDX_W].id     = req.node_id;
		link[IDX_W].best   = '0;
	end

	// Cell b holds the entries whose index has its lowest set bit at b,
	// stored at index >> (b + 1).
	for (genvar b = IDX_W - 1; b >= 0; b--) begin : g_cell
		localparam int unsigned RAM_D = ((TABLE_DEPTH - 1) >> (b + 1)) + 1;
		localparam int unsigned RAM_AW = (RAM_D > 1) ? $clog2(RAM_D) : 1;
		localparam logic [IDX_W-1:0] LEVEL = IDX_W'(1) << b;
		localparam logic [CNT_W-1:0] LOW_MASK = CNT_W'((1 << b) - 1);

		logic              we;
		logic [RAM_AW-1:0] waddr;
		logic [RAM_AW-1:0] raddr;
		run_ent_t          rdata;

		assign we    = append_en && count_q[b] && ((count_q & LOW_MASK) == '0);
		assign waddr = RAM_AW'(count_q >> (b + 1));
		assign raddr = RAM_AW'(link[b+1].prefix >> (b + 1));

		sict_ram #(
			.DEPTH (RAM_D),
			.AW    (RAM_AW)
		) u_ram (
			.clk   (clk),
			.we    (we),
			.waddr (waddr),
			.wdata (wr_ent),
			.raddr (raddr),
			.rdata (rdata)
		);

		sict_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.level  (LEVEL),
			.count  (count_q),
			.up     (link[b+1]),
			.rdata  (rdata),
			.down   (link[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
			count_q    <= CNT_W'(1);
			last_key_q <= '0;
			expected_q <= ID_W'(1);
			dense_q    <= ID_W'(1);
		end else begin
			done_q <= assign_go || link[0].valid;
			if (link[IDX_W].valid) begin
				busy_q <= 1'b1;
			end else if (link[0].valid) begin
				busy_q <= 1'b0;
			end
			if (assign_go) begin
				expected_q <= req.node_id + ID_W'(1);
				dense_q    <= dense_q + ID_W'(1);
			end
			if (append_en) begin
				count_q    <= count_q + CNT_W'(1);
				last_key_q <= req.node_id;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (assign_go) begin
			result_q.new_id        <= dense_q;
			result_q.run_start     <= '0;
			result_q.run_new_start <= '0;
			result_q.status        <= asg_status;
		end else if (link[0].valid) begin
			result_q.new_id        <= '0;
			result_q.run_start     <= link[0].best.key;
			result_q.run_new_start <= link[0].best.val;
			result_q.status        <= STATUS_OK;
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

endmodule
